>>> rtl/core/psa_pkg.sv
`default_nettype none

package psa_pkg;

  // Field widths
  localparam int ChanW   = 8;
  localparam int FactorW = 7;
  localparam int SumW    = 10;
  localparam int DiffW   = ChanW + 1;
  localparam int ProdW   = 16;
  localparam int MagW    = 15;
  localparam int QuotW   = MagW;
  localparam int ValW    = 17;

  // Saturation scale and the divisor that follows from it
  localparam int SatScale  = 100;
  localparam int SatDivRaw = SatScale / 2;
  localparam int SatDiv    = (SatDivRaw < 1) ? 1 : SatDivRaw;
  localparam int DivW      = 8;
  localparam logic [DivW-1:0] SatDivC = DivW'(SatDiv);

  // Reciprocal of the divisor, exact to within one after a single correction
  localparam int RecipShift = 24;
  localparam int RecipW     = RecipShift + 1;
  localparam logic [RecipW-1:0] RecipMultC = RecipW'((1 << RecipShift) / SatDiv);

  // Divide by three for the grey level: floor(x * 683 / 2048) for x up to 765
  localparam int GreyShift = 11;
  localparam int GreyMultW = 10;
  localparam logic [GreyMultW-1:0] GreyMultC = GreyMultW'(683);

  localparam logic [FactorW-1:0] FactorResetC = FactorW'(50);
  localparam logic [ChanW-1:0]   ChanMaxC     = {ChanW{1'b1}};

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } psa_rgb_t;

  typedef struct packed {
    psa_rgb_t         rgb;
    logic [ChanW-1:0] grey;
  } psa_grey_t;

  typedef struct packed {
    logic [2:0][ProdW-1:0] prod;
    logic [ChanW-1:0]      grey;
  } psa_prod_t;

endpackage

`default_nettype wire

>>> rtl/core/psa_grey_stage.sv
`default_nettype none

module psa_grey_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire psa_pkg::psa_rgb_t in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output psa_pkg::psa_grey_t   out_data_o
);
  import psa_pkg::*;

  logic                        valid_q;
  psa_grey_t                   data_d, data_q;
  logic [SumW-1:0]             sum;
  logic [SumW+GreyMultW-1:0]   grey_wide;

  // Mean of the three channels, truncated
  always_comb begin
    sum        = SumW'(in_data_i.red) + SumW'(in_data_i.green) + SumW'(in_data_i.blue);
    grey_wide  = (SumW+GreyMultW)'(sum) * (SumW+GreyMultW)'(GreyMultC);
    data_d.rgb = in_data_i;
    data_d.grey = grey_wide[GreyShift +: ChanW];
  end

  // Advance when the stage is empty or its output drains
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

>>> rtl/core/psa_gain_stage.sv
`default_nettype none

module psa_gain_stage (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire  [psa_pkg::FactorW-1:0]    factor_i,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire psa_pkg::psa_grey_t        in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output psa_pkg::psa_prod_t             out_data_o
);
  import psa_pkg::*;

  logic                          valid_q;
  psa_prod_t                     data_d, data_q;
  logic [2:0][ChanW-1:0]         chan;
  logic signed [DiffW-1:0]       diff [3];
  logic signed [ProdW:0]         prod_full [3];

  assign chan = {in_data_i.rgb.blue, in_data_i.rgb.green, in_data_i.rgb.red};

  // Scale each channel's distance from grey by the gain
  always_comb begin
    data_d.grey = in_data_i.grey;
    for (int i = 0; i < 3; i++) begin
      diff[i]      = $signed({1'b0, chan[i]}) - $signed({1'b0, in_data_i.grey});
      prod_full[i] = diff[i] * $signed({1'b0, factor_i});
      data_d.prod[i] = prod_full[i][ProdW-1:0];
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

>>> rtl/core/psa_div_stage.sv
`default_nettype none

module psa_div_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire psa_pkg::psa_prod_t in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output psa_pkg::psa_rgb_t    out_data_o
);
  import psa_pkg::*;

  // Stage A: magnitude and reciprocal estimate
  logic                          valid_a_q;
  logic [2:0]                    neg_d, neg_q;
  logic [2:0][MagW-1:0]          mag_d, mag_q;
  logic [2:0][QuotW-1:0]         est_d, est_q;
  logic [ChanW-1:0]              grey_a_q;
  logic [MagW+RecipW-1:0]        est_wide [3];
  logic                          ready_a;

  // Stage B: correction, sign, offset and clamp
  logic                          valid_b_q;
  psa_rgb_t                      res_d, res_q;
  logic [MagW+DivW-1:0]          back [3];
  logic [MagW-1:0]               rem [3];
  logic [QuotW-1:0]              quot [3];
  logic signed [ValW-1:0]        val [3];
  logic [2:0][ChanW-1:0]         chan_out;
  logic                          ready_b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i]    = in_data_i.prod[i][ProdW-1];
      mag_d[i]    = neg_d[i] ? MagW'(-in_data_i.prod[i]) : MagW'(in_data_i.prod[i]);
      est_wide[i] = (MagW+RecipW)'(mag_d[i]) * (MagW+RecipW)'(RecipMultC);
      est_d[i]    = est_wide[i][RecipShift +: QuotW];
    end
  end

  assign ready_b    = !valid_b_q || out_ready_i;
  assign ready_a    = !valid_a_q || ready_b;
  assign in_ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (ready_a) begin
      valid_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      neg_q    <= neg_d;
      mag_q    <= mag_d;
      est_q    <= est_d;
      grey_a_q <= in_data_i.grey;
    end
  end

  // Fix the estimate by one, apply the sign and clamp to the channel range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      back[i] = (MagW+DivW)'(est_q[i]) * (MagW+DivW)'(SatDivC);
      rem[i]  = mag_q[i] - back[i][MagW-1:0];
      quot[i] = (rem[i] >= MagW'(SatDivC)) ? est_q[i] + QuotW'(1) : est_q[i];
      val[i]  = neg_q[i] ? $signed(ValW'(grey_a_q)) - $signed(ValW'(quot[i]))
                         : $signed(ValW'(grey_a_q)) + $signed(ValW'(quot[i]));
      if (val[i][ValW-1]) begin
        chan_out[i] = '0;
      end else if (val[i] > $signed(ValW'(ChanMaxC))) begin
        chan_out[i] = ChanMaxC;
      end else begin
        chan_out[i] = val[i][ChanW-1:0];
      end
    end
    res_d.red   = chan_out[0];
    res_d.green = chan_out[1];
    res_d.blue  = chan_out[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (ready_b) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && valid_a_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_b_q;
  assign out_data_o  = res_q;

  // The reciprocal estimate never overshoots the true quotient
  a_est_le_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_a_q |-> (back[0][MagW-1:0] <= mag_q[0]) && (back[1][MagW-1:0] <= mag_q[1])
                  && (back[2][MagW-1:0] <= mag_q[2]))
    else $error("reciprocal estimate above quotient");

  // One correction step is enough
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_a_q |-> (rem[0] < MagW'(2 * SatDiv)) && (rem[1] < MagW'(2 * SatDiv))
                  && (rem[2] < MagW'(2 * SatDiv)))
    else $error("remainder needs more than one correction");

  // A stalled result stays put
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_b_q && !out_ready_i |=> valid_b_q && $stable(res_q))
    else $error("result changed under stall");

  // Stage A does not advance into a full, stalled stage B
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_a_q && valid_b_q && !out_ready_i |=> valid_a_q && $stable(est_q))
    else $error("stage A lost an item under stall");

endmodule

`default_nettype wire

>>> rtl/core/palette_saturation_adjust.sv
// Saturation adjustment of 8-bit RGB palette entries.
//
// Input stream s_axis_*: one entry per transfer, tdata = {blue, green, red}.
// Output stream m_axis_*: one adjusted entry per input, same packing, in order.
// Grey is the truncated mean of the channels; each channel becomes
// grey + (c - grey) * factor / 50, truncated toward zero and clamped to 0..255.
//
// Configuration: cfg_we_i writes cfg_wdata_i into the 7-bit gain at the clock
// edge; write it only while the pipeline is empty. Reset sets the gain to 50
// (colors pass unchanged) and empties the pipeline.
//
// Each entry passes through registered stages in order: grey mean, gain
// multiply, reciprocal multiply, then correction and clamp. Throughput is
// one entry per cycle while m_axis_tready stays high. When the receiver
// holds m_axis_tready low, the output register holds its entry and earlier
// stages keep filling their bubbles; s_axis_tready drops only once every
// stage holds an entry.
`default_nettype none

module palette_saturation_adjust (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [psa_pkg::FactorW-1:0]  cfg_wdata_i,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [23:0]                  s_axis_tdata,  // blue_in, green_in, red_in
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [23:0]                  m_axis_tdata   // blue_out, green_out, red_out
);
  import psa_pkg::*;

  logic [FactorW-1:0] factor_q;
  psa_rgb_t           rgb_in, rgb_out;
  psa_grey_t          grey_data;
  psa_prod_t          prod_data;
  logic               grey_valid, grey_ready;
  logic               prod_valid, prod_ready;

  // Hold the gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FactorResetC;
    end else if (cfg_we_i) begin
      factor_q <= cfg_wdata_i;
    end
  end

  assign rgb_in = s_axis_tdata;

  psa_grey_stage u_grey (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (rgb_in),
    .out_valid_o (grey_valid),
    .out_ready_i (grey_ready),
    .out_data_o  (grey_data)
  );

  psa_gain_stage u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .factor_i    (factor_q),
    .in_valid_i  (grey_valid),
    .in_ready_o  (grey_ready),
    .in_data_i   (grey_data),
    .out_valid_o (prod_valid),
    .out_ready_i (prod_ready),
    .out_data_o  (prod_data)
  );

  psa_div_stage u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prod_valid),
    .in_ready_o  (prod_ready),
    .in_data_i   (prod_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (rgb_out)
  );

  assign m_axis_tdata = rgb_out;

endmodule

`default_nettype wire

>>> tb/palette_saturation_adjust_tb.sv
`timescale 1ns / 1ps

module palette_saturation_adjust_tb;
  import psa_pkg::*;

  localparam int HalfPeriodNs = 6;
  localparam int ResetCycles  = 6;
  localparam int StallLimit   = 5000;
  localparam int DrainCycles  = 8;
  localparam int ChunkItems   = 150;
  localparam int ChunkCount   = 13;

  // Gain settings with a fixed meaning
  localparam logic [FactorW-1:0] GainGrey  = '0;
  localparam logic [FactorW-1:0] GainUnity = FactorResetC;
  localparam logic [FactorW-1:0] GainTop   = FactorW'(99);
  localparam logic [FactorW-1:0] GainMax   = '1;
  localparam logic [FactorW-1:0] GainSweep [5] = '{GainGrey, GainMax, GainTop,
                                                   FactorW'(1), FactorW'(100)};

  localparam logic [ChanW-1:0] ChanEdges [4] = '{8'h00, 8'h01, 8'hFE, 8'hFF};
  localparam string ChanNames [3] = '{"red", "green", "blue"};

  // One directed row: gain, entry, and the result where it is known by hand
  typedef struct packed {
    logic [FactorW-1:0] gain;
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
    bit                 known;
    logic [ChanW-1:0]   want_red;
    logic [ChanW-1:0]   want_green;
    logic [ChanW-1:0]   want_blue;
  } entry_row_t;

  localparam entry_row_t EntryRows [17] = '{
    // unity gain passes colors through
    '{GainUnity, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
    '{GainUnity, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
    '{GainUnity, 8'd255, 8'd0,   8'd0,   1'b1, 8'd255, 8'd0,   8'd0  },
    '{GainUnity, 8'h12,  8'hA5,  8'h5A,  1'b1, 8'h12,  8'hA5,  8'h5A },
    // zero gain gives the truncated mean on every channel
    '{GainGrey,  8'd255, 8'd0,   8'd0,   1'b1, 8'd85,  8'd85,  8'd85 },
    '{GainGrey,  8'd0,   8'd128, 8'd255, 1'b1, 8'd127, 8'd127, 8'd127},
    '{GainGrey,  8'd255, 8'd255, 8'd254, 1'b1, 8'd254, 8'd254, 8'd254},
    // largest gain clamps at both ends
    '{GainMax,   8'd255, 8'd0,   8'd0,   1'b1, 8'd255, 8'd0,   8'd0  },
    '{GainMax,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
    '{GainMax,   8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
    '{GainMax,   8'd100, 8'd101, 8'd102, 1'b0, 8'd0,   8'd0,   8'd0  },
    '{GainTop,   8'd255, 8'd128, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0  },
    '{GainTop,   8'd1,   8'd2,   8'd3,   1'b0, 8'd0,   8'd0,   8'd0  },
    // gain above the nominal range
    '{FactorW'(100), 8'd200, 8'd50, 8'd10, 1'b0, 8'd0, 8'd0, 8'd0    },
    // small negative offsets truncate toward zero
    '{FactorW'(1),   8'd10, 8'd250, 8'd130, 1'b0, 8'd0, 8'd0, 8'd0   },
    '{FactorW'(75),  8'd0,  8'd255, 8'd0,   1'b0, 8'd0, 8'd0, 8'd0   },
    '{GainUnity, 8'd1,   8'd254, 8'd127, 1'b1, 8'd1,   8'd254, 8'd127}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [FactorW-1:0] cfg_wdata = FactorResetC;
  logic               s_valid = 1'b0;
  psa_rgb_t           s_data = '0;
  logic               s_ready;
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [23:0]        m_data;

  logic [FactorW-1:0] gain_q = FactorResetC;
  psa_rgb_t           expected_entries [$];
  int                 mismatches = 0;
  int                 stall_cycles = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;

  palette_saturation_adjust u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  always #(HalfPeriodNs) clk = ~clk;

  // Mix each channel toward or away from the truncated mean, then clamp
  function automatic psa_rgb_t saturate_entry(psa_rgb_t e, logic [FactorW-1:0] gain);
    int chan [3];
    int grey;
    int divisor;
    int v;
    logic [ChanW-1:0] res [3];
    chan[0] = int'(e.red);
    chan[1] = int'(e.green);
    chan[2] = int'(e.blue);
    grey = (chan[0] + chan[1] + chan[2]) / 3;
    divisor = SatScale / 2;
    if (divisor < 1) begin
      divisor = 1;
    end
    for (int k = 0; k < 3; k++) begin
      v = grey + ((chan[k] - grey) * int'(gain)) / divisor;
      if (v < 0) begin
        v = 0;
      end
      if (v > 255) begin
        v = 255;
      end
      res[k] = ChanW'(v);
    end
    return '{blue: res[2], green: res[1], red: res[0]};
  endfunction

  // Offer one entry, hold it until the transfer, and queue its result
  task automatic push_entry(psa_rgb_t e, bit known, psa_rgb_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= e;
    do @(posedge clk); while (!s_ready);
    expected_entries.push_back(known ? want : saturate_entry(e, gain_q));
  endtask

  // Stop sending, drain the pipeline, then write the gain
  task automatic set_gain(logic [FactorW-1:0] gain);
    s_valid <= 1'b0;
    while (expected_entries.size() != 0) begin
      @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_wdata <= gain;
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_q = gain;
  endtask

  // Randomize the receiver and check each output transfer
  always @(posedge clk) begin : out_check
    psa_rgb_t got;
    psa_rgb_t want;
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (rst_n && m_valid && m_ready) begin
      got = m_data;
      if (expected_entries.size() == 0) begin
        $display("%0t: unexpected output %h", $time, got);
        mismatches++;
      end else begin
        want = expected_entries.pop_front();
        for (int k = 0; k < 3; k++) begin
          if (want[k*ChanW +: ChanW] !== got[k*ChanW +: ChanW]) begin
            $display("%0t: %s expected %0d, got %0d", $time, ChanNames[k],
                     want[k*ChanW +: ChanW], got[k*ChanW +: ChanW]);
            mismatches++;
          end
        end
      end
    end
  end

  // Count cycles without any transfer and abort on a hang
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("palette_saturation_adjust regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    psa_rgb_t entry;
    psa_rgb_t want;
    int       kind;
    logic [ChanW-1:0] base;
    logic [FactorW-1:0] gain;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    send_idle_pct = 15;
    recv_idle_pct = 63;
    foreach (EntryRows[i]) begin
      if (EntryRows[i].gain != gain_q) begin
        set_gain(EntryRows[i].gain);
      end
      entry = '{blue: EntryRows[i].blue, green: EntryRows[i].green, red: EntryRows[i].red};
      want  = '{blue: EntryRows[i].want_blue, green: EntryRows[i].want_green,
                red: EntryRows[i].want_red};
      push_entry(entry, EntryRows[i].known, want);
    end

    // Random chunks, one gain each, idling pattern by phase
    for (int chunk = 0; chunk < ChunkCount; chunk++) begin
      if (chunk < 5) begin
        send_idle_pct = 15;
        recv_idle_pct = 63;
      end else if (chunk < 10) begin
        send_idle_pct = 63;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (chunk < 5) begin
        gain = GainSweep[chunk];
      end else begin
        case ($urandom_range(3))
          0, 1:    gain = FactorW'($urandom_range(99));
          2:       gain = FactorW'($urandom_range(127, 100));
          default: gain = GainUnity;
        endcase
      end
      set_gain(gain);
      repeat (ChunkItems) begin
        kind = $urandom_range(9);
        entry = 24'($urandom);
        if (kind >= 6 && kind < 8) begin
          // near-grey entries
          base = ChanW'($urandom_range(255));
          entry.red   = base ^ ChanW'($urandom_range(3));
          entry.green = base ^ ChanW'($urandom_range(3));
          entry.blue  = base ^ ChanW'($urandom_range(3));
        end else if (kind == 8) begin
          // one channel pinned to a rail
          case ($urandom_range(2))
            0:       entry.red   = $urandom_range(1) ? ChanMaxC : '0;
            1:       entry.green = $urandom_range(1) ? ChanMaxC : '0;
            default: entry.blue  = $urandom_range(1) ? ChanMaxC : '0;
          endcase
        end else if (kind == 9) begin
          entry.red   = ChanEdges[$urandom_range(3)];
          entry.green = ChanEdges[$urandom_range(3)];
          entry.blue  = ChanEdges[$urandom_range(3)];
        end
        push_entry(entry, 1'b0, '0);
      end
    end

    // Wait for the last results, then let the bench idle before the report
    s_valid <= 1'b0;
    while (expected_entries.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("palette_saturation_adjust regression: pass");
    end else begin
      $display("palette_saturation_adjust regression: fail");
    end
    $finish;
  end

endmodule
